// File: rtl/assert_macros.svh
// Assertion macros used by the joypad port registers top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JPR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define JPR_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JPR_ASSERT(name, prop, msg)
`define JPR_ASSERT_RST(name, prop, msg)
`endif
`endif

// File: rtl/jpr_pkg.sv
// Types, constants and decode functions of the joypad port registers.
package jpr_pkg;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  localparam logic [1:0] OFF_MATRIX = 2'd0;
  localparam logic [1:0] OFF_SELECT = 2'd1;
  localparam logic [1:0] OFF_FIRE   = 2'd2;
  localparam logic [1:0] OFF_SPARE  = 2'd3;

  localparam logic [4:0] IDX_FIRE_A = 5'd16;
  localparam logic [4:0] IDX_FIRE_B = 5'd17;
  localparam logic [4:0] IDX_FIRE_C = 5'd18;
  localparam logic [4:0] IDX_PAUSE  = 5'd19;
  localparam logic [4:0] IDX_OPTION = 5'd20;

  localparam logic [3:0] SEL_E = 4'hE;
  localparam logic [3:0] SEL_D = 4'hD;
  localparam logic [3:0] SEL_B = 4'hB;
  localparam logic [3:0] SEL_7 = 4'h7;

  localparam logic [15:0] READ_IDLE = 16'hFFFF;
  localparam logic [15:0] FIRE_BASE = 16'hFF6F;

  localparam int NUM_BYTES = 4;

  typedef struct packed {
    logic        func;
    logic [1:0]  word_offset;
    logic [15:0] write_data;
    logic [20:0] pad0_buttons;
    logic [20:0] pad1_buttons;
  } req_t;

  typedef struct packed {
    logic [7:0] row_sel;
    logic       pads_en;
    logic       audio_en;
  } state_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] row;
  } row_t;

  function automatic row_t pad0_row(input logic [3:0] sel);
    row_t r;
    r.hit = 1'b1;
    r.row = 2'd0;
    unique case (sel)
      SEL_E:   r.row = 2'd0;
      SEL_D:   r.row = 2'd1;
      SEL_B:   r.row = 2'd2;
      SEL_7:   r.row = 2'd3;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic row_t pad1_row(input logic [3:0] sel);
    row_t r;
    r.hit = 1'b1;
    r.row = 2'd0;
    unique case (sel)
      SEL_7:   r.row = 2'd0;
      SEL_B:   r.row = 2'd1;
      SEL_D:   r.row = 2'd2;
      SEL_E:   r.row = 2'd3;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] fire_idx(input logic [1:0] row);
    logic [4:0] idx;
    unique case (row)
      2'd0:    idx = IDX_FIRE_A;
      2'd1:    idx = IDX_FIRE_B;
      2'd2:    idx = IDX_FIRE_C;
      default: idx = IDX_OPTION;
    endcase
    return idx;
  endfunction

  function automatic logic [3:0] group_bits(input logic [20:0] pad, input logic [1:0] row);
    logic [3:0] g;
    unique case (row)
      2'd0:    g = pad[3:0];
      2'd1:    g = pad[7:4];
      2'd2:    g = pad[11:8];
      default: g = pad[15:12];
    endcase
    return g;
  endfunction

endpackage

// File: rtl/jpr_if.sv
// Valid/ready channel interfaces for port accesses and read results.
interface jpr_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [1:0]  word_offset;
  logic [15:0] write_data;
  logic [20:0] pad0_buttons;
  logic [20:0] pad1_buttons;

  modport source (output valid, func, word_offset, write_data, pad0_buttons, pad1_buttons,
                  input ready);
  modport sink (input valid, func, word_offset, write_data, pad0_buttons, pad1_buttons,
                output ready);
endinterface

interface jpr_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// File: rtl/jpr_regfile.sv
// Four-byte port register file with the pad and audio enable bits.
module jpr_regfile (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  logic [1:0]      wr_offset,
  input  logic [15:0]     wr_data,
  output jpr_pkg::state_t state
);

  logic [7:0] port_bytes [jpr_pkg::NUM_BYTES];
  logic       pads_en;
  logic       audio_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jpr_pkg::NUM_BYTES; i++) begin
        port_bytes[i] <= 8'h00;
      end
      pads_en  <= 1'b0;
      audio_en <= 1'b0;
    end else if (wr_en) begin
      for (int i = 0; i < jpr_pkg::NUM_BYTES; i++) begin
        if (wr_offset == 2'(i)) begin
          port_bytes[i] <= wr_data[15:8];
        end else if (i > 0 && wr_offset == 2'(i - 1)) begin
          port_bytes[i] <= wr_data[7:0];
        end
      end
      if (wr_offset == jpr_pkg::OFF_MATRIX) begin
        audio_en <= wr_data[8];
        pads_en  <= wr_data[15];
      end
    end
  end

  assign state.row_sel  = port_bytes[jpr_pkg::OFF_SELECT];
  assign state.pads_en  = pads_en;
  assign state.audio_en = audio_en;

endmodule

// File: rtl/jpr_read_decode.sv
// Read data decode from the row selects and the button inputs.
module jpr_read_decode (
  input  jpr_pkg::req_t   req,
  input  jpr_pkg::state_t state,
  input  logic            ntsc,
  output logic [15:0]     read_data
);

  jpr_pkg::row_t r0;
  jpr_pkg::row_t r1;
  logic [3:0]    g0;
  logic [3:0]    g1;

  always_comb begin
    r0 = jpr_pkg::pad0_row(state.row_sel[3:0]);
    r1 = jpr_pkg::pad1_row(state.row_sel[7:4]);
    g0 = jpr_pkg::group_bits(req.pad0_buttons, r0.row);
    g1 = jpr_pkg::group_bits(req.pad1_buttons, r1.row);
    read_data = jpr_pkg::READ_IDLE;
    case (req.word_offset)
      jpr_pkg::OFF_MATRIX: begin
        if (state.pads_en) begin
          if (r0.hit) begin
            read_data[11:8] = ~g0;
            if (r0.row != 2'd0) begin
              read_data[{2'b00, r0.row}] = 1'b0;
            end
          end
          if (r1.hit) begin
            read_data[15:12] = ~g1;
            read_data[4'd7 - {2'b00, r1.row}] = 1'b0;
          end
        end
      end
      jpr_pkg::OFF_FIRE: begin
        read_data    = jpr_pkg::FIRE_BASE;
        read_data[4] = ntsc;
        if (state.pads_en) begin
          if (r0.hit) begin
            if (req.pad0_buttons[jpr_pkg::fire_idx(r0.row)]) begin
              read_data[1] = 1'b0;
            end
            if (r0.row == 2'd0 && req.pad0_buttons[jpr_pkg::IDX_PAUSE]) begin
              read_data[0] = 1'b0;
            end
          end
          if (r1.hit) begin
            if (req.pad1_buttons[jpr_pkg::fire_idx(r1.row)]) begin
              read_data[3] = 1'b0;
            end
            if (r1.row == 2'd0 && req.pad1_buttons[jpr_pkg::IDX_PAUSE]) begin
              read_data[2] = 1'b0;
            end
          end
        end
      end
      default: read_data = jpr_pkg::READ_IDLE;
    endcase
  end

endmodule

// File: rtl/joypad_port_registers.sv
// Top level of the two-pad joystick port registers.
// Usage: each transaction on req is one port access. func selects read or
// write, word_offset the byte offset, write_data the data of a write, and
// pad0_buttons and pad1_buttons carry the current pressed flags of both pads.
// A write updates the register file and produces no transaction on rsp.
// A read produces exactly one rsp transaction carrying read_data.
// A read is held in the input register, where the decode reads the
// register file, and is then captured in the result register once it is
// free, so rsp valid rises after both registers. Writes take effect as they
// leave the input register, so later reads always see them. Throughput is
// one access per cycle while no read waits on a stalled rsp.
// When the receiver stalls rsp, the result register holds its data, and the
// input register keeps taking writes; a waiting read holds req ready low.
// cfg_we with cfg_wdata sets the NTSC identification bit, reset value one.
// Reset clears the register file, both enable bits and both pipeline stages.
`include "assert_macros.svh"

module joypad_port_registers (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  jpr_req_if.sink   req,
  jpr_rsp_if.source rsp
);

  logic            ntsc;
  logic            s1_valid;
  jpr_pkg::req_t   s1;
  logic            s1_is_write;
  logic            s1_write;
  logic            s1_adv;
  logic            out_free;
  logic            out_load;
  logic            out_valid;
  logic [15:0]     out_data;
  logic [15:0]     read_next;
  jpr_pkg::state_t state;

  assign s1_is_write = (s1.func == jpr_pkg::FUNC_WRITE);
  assign s1_write    = s1_valid && s1_is_write;
  assign out_free    = !out_valid || rsp.ready;
  assign s1_adv      = s1_is_write || out_free;
  assign out_load    = s1_valid && !s1_is_write && s1_adv;
  assign req.ready   = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ntsc <= 1'b1;
    end else if (cfg_we) begin
      ntsc <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1.func         <= req.func;
      s1.word_offset  <= req.word_offset;
      s1.write_data   <= req.write_data;
      s1.pad0_buttons <= req.pad0_buttons;
      s1.pad1_buttons <= req.pad1_buttons;
    end
  end

  jpr_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (s1_write),
    .wr_offset (s1.word_offset),
    .wr_data   (s1.write_data),
    .state     (state)
  );

  jpr_read_decode u_decode (
    .req       (s1),
    .state     (state),
    .ntsc      (ntsc),
    .read_data (read_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= read_next;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_data;

  `JPR_ASSERT(a_read_yields_result, out_load |=> out_valid, "read result not loaded")
  `JPR_ASSERT(a_write_no_result, s1_write && out_free |=> !out_valid, "write produced a result")
  `JPR_ASSERT(a_ready_when_empty, !out_valid |-> req.ready, "input stalled while output empty")
  `JPR_ASSERT_RST(a_reset_clears, rst |=> !out_valid && !s1_valid, "pipeline not reset")

endmodule
